// ===== src/hmr_pkg.sv =====
// Shared types and constants for the histogram mode and repeat finder.
// No dependencies; imported by every module of the block.
package hmr_pkg;

    localparam int NUM_BINS_DEF  = 16;
    localparam int MAX_COUNT_DEF = 1024;
    localparam int VAL_W         = 4;
    localparam int CFG_W         = 11;
    localparam int QUEUE_DEPTH   = 4;
    localparam logic [CFG_W-1:0] REPEAT_RESET = 11'd2;

    typedef struct packed {
        logic             in_range;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_item;

    typedef enum logic [1:0] {
        BK_COUNT,
        BK_SCAN,
        BK_FINISH
    } t_back_state;

    function automatic int scan_bins(input int n);
        return (n < (1 << VAL_W)) ? n : (1 << VAL_W);
    endfunction

endpackage

// ===== src/histogram_mode_and_repeats.sv =====
// Histogram mode and repeat finder. Items are taken one per cycle while busy is low and
// reach the bins via the front register and the queue, later while the queue holds items.
// A set's last item starts a scan over the min(NUM_BINS,16) bins of the bin store and a
// closing state; the front stage and a 4-beat queue absorb 5 further items before busy rises.
// Results come one per cycle at most. The receiver cannot stall. Synchronous
// reset clears the bins, the queue and the result strobe and sets min_repeat to 2.
module histogram_mode_and_repeats #(
    parameter int NUM_BINS  = hmr_pkg::NUM_BINS_DEF,
    parameter int MAX_COUNT = hmr_pkg::MAX_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [hmr_pkg::VAL_W-1:0] i_sample_value,
    input  logic                      i_last_sample,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [hmr_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic [hmr_pkg::VAL_W-1:0] o_repeated_value,
    output logic                      o_has_value,
    output logic [hmr_pkg::VAL_W-1:0] o_repeat_index,
    output logic [hmr_pkg::VAL_W-1:0] o_mode_value,
    output logic                      o_end_of_list
);
    import hmr_pkg::*;

    logic [CFG_W-1:0] r_min_repeat;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_item            front_item;
    t_item            q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_repeat <= REPEAT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_repeat <= i_cfg_data;
        end
    end

    hmr_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sample_value (i_sample_value),
        .i_last_sample  (i_last_sample),
        .i_q_full       (q_full),
        .o_busy         (busy),
        .o_push         (q_push),
        .o_item         (front_item)
    );

    hmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    hmr_back #(
        .NUM_BINS  (NUM_BINS),
        .MAX_COUNT (MAX_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_item           (q_item),
        .i_min_repeat     (r_min_repeat),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .o_repeated_value (o_repeated_value),
        .o_has_value      (o_has_value),
        .o_repeat_index   (o_repeat_index),
        .o_mode_value     (o_mode_value),
        .o_end_of_list    (o_end_of_list)
    );

endmodule

// ===== src/hmr_front.sv =====
// Front end: takes items on the start/busy handshake, marks whether the
// sample lands in a bin, and pushes them into the queue. Uses hmr_pkg.
module hmr_front #(
    parameter int NUM_BINS = hmr_pkg::NUM_BINS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hmr_pkg::VAL_W-1:0] i_sample_value,
    input  logic                      i_last_sample,
    input  logic                      i_q_full,
    output logic                      o_busy,
    output logic                      o_push,
    output hmr_pkg::t_item            o_item
);
    import hmr_pkg::*;

    localparam int SCAN_BINS = scan_bins(NUM_BINS);
    localparam logic [VAL_W:0] SCAN_LIM = (VAL_W+1)'(SCAN_BINS);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_busy = r_valid & i_q_full;
    assign o_push = r_valid & ~i_q_full;
    assign accept = i_start & ~o_busy;
    assign o_item = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.in_range <= ({1'b0, i_sample_value} < SCAN_LIM);
            r_item.value    <= i_sample_value;
            r_item.last     <= i_last_sample;
        end
    end

endmodule

// ===== src/hmr_queue.sv =====
// Short FIFO between front and back end, QUEUE_DEPTH beats deep.
// Uses hmr_pkg for the item type and depth.
module hmr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hmr_pkg::t_item i_item,
    input  logic           i_pop,
    output hmr_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);
    import hmr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == DEPTH);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/hmr_back.sv =====
// Back end: counts items into saturating bins, tracks the mode, and on the
// last item scans the bins one per cycle to emit the repeat list. Uses hmr_pkg.
module hmr_back #(
    parameter int NUM_BINS  = hmr_pkg::NUM_BINS_DEF,
    parameter int MAX_COUNT = hmr_pkg::MAX_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  hmr_pkg::t_item            i_item,
    input  logic [hmr_pkg::CFG_W-1:0] i_min_repeat,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [hmr_pkg::VAL_W-1:0] o_repeated_value,
    output logic                      o_has_value,
    output logic [hmr_pkg::VAL_W-1:0] o_repeat_index,
    output logic [hmr_pkg::VAL_W-1:0] o_mode_value,
    output logic                      o_end_of_list
);
    import hmr_pkg::*;

    localparam int SCAN_BINS = scan_bins(NUM_BINS);
    localparam int IDX_W     = (SCAN_BINS > 1) ? $clog2(SCAN_BINS) : 1;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_BINS - 1);

    t_back_state      r_state, n_state;
    logic [CNT_W-1:0] r_bins [SCAN_BINS];
    logic [CNT_W-1:0] r_max;
    logic [IDX_W-1:0] r_mode;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0] r_pend, n_pend;
    logic [VAL_W-1:0] r_rep_cnt, n_rep_cnt;

    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic             r_out_has, n_out_has;
    logic [VAL_W-1:0] r_out_index, n_out_index;
    logic             r_out_end, n_out_end;
    logic [VAL_W-1:0] r_out_mode, n_out_mode;

    logic [IDX_W-1:0] bin_sel;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] cnt_rd;
    logic [CNT_W-1:0] cnt_inc;
    logic             can_inc;
    logic             bump;
    logic             qualify;
    logic             finish;

    assign bin_sel = i_item.value[IDX_W-1:0];
    assign rd_addr = (r_state == BK_COUNT) ? bin_sel : r_idx;
    assign cnt_rd  = r_bins[rd_addr];
    assign cnt_inc = cnt_rd + 1'b1;
    assign can_inc = i_item.in_range && (cnt_rd != CNT_MAX);
    assign o_pop   = (r_state == BK_COUNT) && !i_empty;
    assign bump    = o_pop && can_inc;
    assign qualify = (CMP_W'(cnt_rd) >= CMP_W'(i_min_repeat));
    assign finish  = (r_state == BK_FINISH);

    assign o_valid          = r_out_valid;
    assign o_repeated_value = r_out_value;
    assign o_has_value      = r_out_has;
    assign o_repeat_index   = r_out_index;
    assign o_mode_value     = r_out_mode;
    assign o_end_of_list    = r_out_end;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_rep_cnt    = r_rep_cnt;
        n_out_valid  = 1'b0;
        n_out_value  = r_out_value;
        n_out_has    = r_out_has;
        n_out_index  = r_out_index;
        n_out_end    = r_out_end;
        n_out_mode   = r_out_mode;
        case (r_state)
            BK_COUNT: begin
                if (!i_empty && i_item.last) begin
                    n_state = BK_SCAN;
                    n_idx   = '0;
                end
            end
            BK_SCAN: begin
                if (qualify) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_value = VAL_W'(r_pend);
                        n_out_has   = 1'b1;
                        n_out_index = r_rep_cnt;
                        n_out_end   = 1'b0;
                        n_out_mode  = VAL_W'(r_mode);
                        n_rep_cnt   = r_rep_cnt + 1'b1;
                    end
                    n_pend       = r_idx;
                    n_pend_valid = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = BK_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            BK_FINISH: begin
                n_out_valid = 1'b1;
                n_out_mode  = VAL_W'(r_mode);
                n_out_end   = 1'b1;
                if (r_pend_valid) begin
                    n_out_value = VAL_W'(r_pend);
                    n_out_has   = 1'b1;
                    n_out_index = r_rep_cnt;
                end else begin
                    n_out_value = '0;
                    n_out_has   = 1'b0;
                    n_out_index = '0;
                end
                n_pend_valid = 1'b0;
                n_rep_cnt    = '0;
                n_state      = BK_COUNT;
            end
            default: begin
                n_state = BK_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_COUNT;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_rep_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_rep_cnt    <= n_rep_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_out_value <= n_out_value;
        r_out_has   <= n_out_has;
        r_out_index <= n_out_index;
        r_out_end   <= n_out_end;
        r_out_mode  <= n_out_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            for (int b = 0; b < SCAN_BINS; b++) begin
                r_bins[b] <= '0;
            end
        end else if (bump) begin
            r_bins[bin_sel] <= cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_max  <= '0;
            r_mode <= '0;
        end else if (bump) begin
            if (cnt_inc > r_max) begin
                r_max  <= cnt_inc;
                r_mode <= bin_sel;
            end else if (cnt_inc == r_max && bin_sel < r_mode) begin
                r_mode <= bin_sel;
            end
        end
    end

endmodule

// ===== src/hmr_checker.sv =====
// Port-level checks on the result stream of the histogram mode finder.
// Bound to histogram_mode_and_repeats; uses hmr_pkg for widths.
module hmr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic [hmr_pkg::VAL_W-1:0] o_repeated_value,
    input logic                      o_has_value,
    input logic [hmr_pkg::VAL_W-1:0] o_repeat_index,
    input logic [hmr_pkg::VAL_W-1:0] o_mode_value,
    input logic                      o_end_of_list
);
    import hmr_pkg::*;

    a_empty_run_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_value |-> o_end_of_list && o_repeat_index == '0)
        else $error("empty result not a lone final beat");

    a_gap_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_list |=> !o_valid)
        else $error("result directly after end of list");

    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && !$past(o_end_of_list) |->
            o_mode_value == $past(o_mode_value) &&
            o_repeat_index == VAL_W'($past(o_repeat_index) + 1'b1) &&
            o_repeated_value > $past(o_repeated_value))
        else $error("adjacent beats of a run out of order");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_value |-> o_repeat_index <= o_repeated_value)
        else $error("repeat index exceeds value");

endmodule

bind histogram_mode_and_repeats hmr_checker u_chk (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for histogram_mode_and_repeats: sends sample sets, predicts
// the repeat list and mode of each set and checks every result beat in order.
// Depends on hmr_pkg and the histogram_mode_and_repeats top level.
module tb_top;
    import hmr_pkg::*;

    localparam int BINS          = 16;
    localparam int SAT_COUNT     = MAX_COUNT_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 230;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             has_value;
        logic [VAL_W-1:0] index;
        logic [VAL_W-1:0] mode;
        logic             end_of_list;
    } t_repeat_beat;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [VAL_W-1:0] i_sample_value;
    logic             i_last_sample;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             o_valid;
    logic [VAL_W-1:0] o_repeated_value;
    logic             o_has_value;
    logic [VAL_W-1:0] o_repeat_index;
    logic [VAL_W-1:0] o_mode_value;
    logic             o_end_of_list;

    logic [CFG_W-1:0] bin_model [BINS];
    logic [CFG_W-1:0] threshold_model;
    t_repeat_beat     expected_beats [$];
    int               mismatches  = 0;
    int               cycle_count = 0;
    bit               no_gaps     = 1'b0;
    bit               start_high  = 1'b0;

    histogram_mode_and_repeats dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample_value   (i_sample_value),
        .i_last_sample    (i_last_sample),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_repeated_value (o_repeated_value),
        .o_has_value      (o_has_value),
        .o_repeat_index   (o_repeat_index),
        .o_mode_value     (o_mode_value),
        .o_end_of_list    (o_end_of_list)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic string beat_text(input t_repeat_beat beat);
        return $sformatf("val=%0d has=%0d idx=%0d mode=%0d eol=%0d", beat.value,
                         beat.has_value, beat.index, beat.mode, beat.end_of_list);
    endfunction

    task automatic log_mismatch(input string what, input t_repeat_beat want,
                                input t_repeat_beat got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: expected %s, got %s", $realtime, what, beat_text(want),
                     beat_text(got));
    endtask

    always @(posedge i_clk) begin
        t_repeat_beat got;
        t_repeat_beat want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            got = '{o_repeated_value, o_has_value, o_repeat_index, o_mode_value,
                    o_end_of_list};
            if (expected_beats.size() == 0) begin
                log_mismatch("unexpected beat", '0, got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want)
                    log_mismatch("beat mismatch", want, got);
            end
        end
    end

    // Count one sample; on the last of a set, scan the bins and queue the repeat list.
    task automatic count_sample(input logic [VAL_W-1:0] value, input logic last);
        logic [VAL_W-1:0] mode_bin;
        t_repeat_beat     beat;
        int               hits;
        int               seen;
        int               b;
        if (bin_model[value] < SAT_COUNT)
            bin_model[value]++;
        if (last) begin
            mode_bin = '0;
            for (b = 1; b < BINS; b++)
                if (bin_model[b] > bin_model[mode_bin])
                    mode_bin = VAL_W'(b);
            hits = 0;
            for (b = 0; b < BINS; b++)
                if (bin_model[b] >= threshold_model)
                    hits++;
            seen = 0;
            for (b = 0; b < BINS; b++) begin
                if (bin_model[b] >= threshold_model) begin
                    beat.value       = VAL_W'(b);
                    beat.has_value   = 1'b1;
                    beat.index       = VAL_W'(seen);
                    beat.mode        = mode_bin;
                    beat.end_of_list = (seen == hits - 1);
                    expected_beats.push_back(beat);
                    seen++;
                end
            end
            if (hits == 0)
                expected_beats.push_back('{'0, 1'b0, '0, mode_bin, 1'b1});
            for (b = 0; b < BINS; b++)
                bin_model[b] = '0;
        end
    endtask

    task automatic idle_sender();
        if (start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    task automatic sender_gap();
        int gap;
        if (no_gaps)
            gap = 0;
        else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(6, 40);
        else
            gap = $urandom_range(0, 2);
        if (gap > 0) begin
            idle_sender();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [VAL_W-1:0] value, input logic last);
        start          <= 1'b1;
        start_high     = 1'b1;
        i_sample_value <= value;
        i_last_sample  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        count_sample(value, last);
        sender_gap();
    endtask

    task automatic wait_results_drained();
        idle_sender();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_repeat(input logic [CFG_W-1:0] threshold);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= threshold;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        threshold_model = threshold;
    endtask

    task automatic test_reset_threshold();
        send_sample(4'd15, 1'b0);
        send_sample(4'd0, 1'b0);
        send_sample(4'd15, 1'b0);
        send_sample(4'd0, 1'b0);
        send_sample(4'd15, 1'b1);
        send_sample(4'd5, 1'b1);
        send_sample(4'd9, 1'b0);
        send_sample(4'd3, 1'b0);
        send_sample(4'd3, 1'b0);
        send_sample(4'd9, 1'b1);
    endtask

    task automatic test_threshold_extremes();
        int v;
        write_min_repeat(11'd1);
        for (v = BINS - 1; v >= 0; v--)
            send_sample(VAL_W'(v), v == 0);
        write_min_repeat(11'd0);
        send_sample(4'd4, 1'b1);
        write_min_repeat(11'h7FF);
        send_sample(4'd15, 1'b0);
        send_sample(4'd15, 1'b1);
    endtask

    task automatic test_random_sets();
        logic [CFG_W-1:0] thresholds [5];
        logic [VAL_W-1:0] base;
        int               phase;
        int               sent;
        int               sets;
        int               length;
        int               pool;
        int               n;
        thresholds = '{11'd2, 11'd1, 11'd3, 11'(REPEAT_RESET), 11'd0};
        thresholds[4] = 11'($urandom_range(0, 5));
        sent = 0;
        for (phase = 0; phase < 5; phase++) begin
            write_min_repeat(thresholds[phase]);
            sets = 0;
            while (sent < (phase + 1) * RANDOM_ITEMS / 5) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                length  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                pool    = $urandom_range(1, 6);
                base    = VAL_W'($urandom_range(0, BINS - 1));
                for (n = 0; n < length; n++)
                    send_sample(base + VAL_W'($urandom_range(0, pool - 1)),
                                n == length - 1);
                sent += length;
                sets++;
                if (phase == 1 && sets == 3)
                    wait_results_drained();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int b;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_sample_value <= '0;
        i_last_sample  <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        for (b = 0; b < BINS; b++)
            bin_model[b] = '0;
        threshold_model = REPEAT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_threshold();
        test_threshold_extremes();
        test_random_sets();
        wait_results_drained();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
